// File: hdl/bpa_pkg.sv
// shared widths, command codes and status codes of the buddy page allocator
package bpa_pkg;

    localparam int CMD_W    = 1;
    localparam int COUNT_W  = 11;
    localparam int PAGE_W   = 10;
    localparam int STATUS_W = 2;
    localparam int USED_W   = 11;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd3;

endpackage

// File: hdl/bpa_if.sv
// request and response channel interfaces of the buddy page allocator
interface bpa_req_if;
    logic                          valid;
    logic                          ready;
    logic [bpa_pkg::CMD_W-1:0]     cmd;
    logic [bpa_pkg::COUNT_W-1:0]   page_count;
    logic [bpa_pkg::PAGE_W-1:0]    page_index;

    modport source (output valid, output cmd, output page_count, output page_index,
                    input ready);
    modport sink (input valid, input cmd, input page_count, input page_index,
                  output ready);
endinterface

interface bpa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bpa_pkg::STATUS_W-1:0]  status;
    logic [bpa_pkg::PAGE_W-1:0]    start_page;
    logic [bpa_pkg::USED_W-1:0]    used_pages;

    modport source (output valid, output status, output start_page, output used_pages,
                    input ready);
    modport sink (input valid, input status, input start_page, input used_pages,
                  output ready);
endinterface

// File: hdl/bpa_size_dec.sv
// page count check and round-up to a power-of-two block order
module bpa_size_dec #(
    parameter int LEAVES = 1024
) (
    input  logic [bpa_pkg::COUNT_W-1:0]       page_count,
    output logic [$clog2($clog2(LEAVES)+1)-1:0] order,
    output logic                              bad
);

    localparam int LVL  = $clog2(LEAVES);
    localparam int KW   = $clog2(LVL + 1);
    localparam int CMPW = (LVL + 1 > bpa_pkg::COUNT_W) ? LVL + 1 : bpa_pkg::COUNT_W;

    logic [bpa_pkg::COUNT_W-1:0] cnt_m1;
    logic [3:0]                  nbits;
    logic [CMPW-1:0]             cnt_ext;

    always_comb
    begin
        cnt_m1 = page_count - bpa_pkg::COUNT_W'(1);
        nbits  = 4'd0;
        // bit length of count-1 is the ceiling log2 of count
        for (int i = 0; i < bpa_pkg::COUNT_W; i++)
        begin
            if (cnt_m1[i])
            begin
                nbits = 4'(i + 1);
            end
        end
        cnt_ext = CMPW'(page_count);
        bad     = (page_count == '0) || (cnt_ext > CMPW'(LEAVES));
        order   = KW'(nbits);
    end

endmodule

// File: hdl/buddy_page_allocator.sv
// buddy page allocator: mask tree in one dual-read memory, walked one level per cycle
// one command at a time: the next is taken once the result sits in the output register;
//   errors found at the request go straight to the result without a tree walk
// reset: a clearing pass writes the free masks of all 2*LEAVES-1 nodes before any transfer
module buddy_page_allocator #(
    parameter int LEAVES = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    bpa_req_if.sink   req,
    bpa_rsp_if.source rsp
);

    localparam int LVL   = $clog2(LEAVES);
    localparam int NW    = LVL + 1;
    localparam int MW    = LVL + 1;
    localparam int KW    = $clog2(LVL + 1);
    localparam int DEPTH = 2 * LEAVES;
    localparam int CW    = (LVL + 1 > bpa_pkg::USED_W) ? LVL + 1 : bpa_pkg::USED_W;
    localparam int XW    = NW + bpa_pkg::PAGE_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_AROOT = 3'd2;
    localparam logic [2:0] S_ADOWN = 3'd3;
    localparam logic [2:0] S_FSRCH = 3'd4;
    localparam logic [2:0] S_UP    = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    function automatic logic [MW-1:0] full_mask(input logic [KW-1:0] h);
        logic [KW:0] s;
        s = {1'b0, h} + (KW+1)'(1);
        return ~({MW{1'b1}} << s);
    endfunction

    logic [MW-1:0] mem [DEPTH];

    logic [2:0]                   state_reg, state_next;
    logic [NW-1:0]                node_reg, node_next;
    logic [KW-1:0]                h_reg, h_next;
    logic [KW-1:0]                k_reg, k_next;
    logic [MW-1:0]                val_reg, val_next;
    logic                         free_reg, free_next;
    logic [CW-1:0]                used_reg, used_next;
    logic [bpa_pkg::STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic [bpa_pkg::PAGE_W-1:0]   pend_start_reg, pend_start_next;
    logic                         out_valid_reg, out_valid_next;
    logic [bpa_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [bpa_pkg::PAGE_W-1:0]   out_start_reg, out_start_next;
    logic [bpa_pkg::USED_W-1:0]   out_used_reg, out_used_next;

    logic [MW-1:0] rd_a_reg, rd_b_reg;
    logic          rd_en, wr_en;
    logic [NW-1:0] rd_a_addr, rd_b_addr, wr_addr;
    logic [MW-1:0] wr_data;

    logic [KW-1:0] order;
    logic          size_bad;
    logic          accept;
    logic [MW-1:0] bit_k;
    logic          take_right;
    logic [NW-1:0] chosen, parent, node_inc, start_node;
    logic [MW-1:0] chosen_mask, merged;
    logic [KW-1:0] h_dec, h_inc;
    logic [XW-1:0] start_ext, page_ext;

    bpa_size_dec #(
        .LEAVES (LEAVES)
    ) u_size_dec (
        .page_count (req.page_count),
        .order      (order),
        .bad        (size_bad)
    );

    assign req.ready      = (state_reg == S_IDLE);
    assign accept         = req.valid && req.ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.start_page = out_start_reg;
    assign rsp.used_pages = out_used_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_a_addr];
            rd_b_reg <= mem[rd_b_addr];
        end
    end

    always_comb
    begin
        bit_k       = MW'(1) << k_reg;
        take_right  = (rd_b_reg & bit_k) != '0;
        chosen      = {node_reg[NW-2:0], take_right};
        chosen_mask = take_right ? rd_b_reg : rd_a_reg;
        h_dec       = h_reg - KW'(1);
        h_inc       = h_reg + KW'(1);
        parent      = node_reg >> 1;
        node_inc    = node_reg + NW'(1);
        // block start is the node shifted to leaf level, minus the leaf base
        start_node  = (state_reg == S_AROOT) ? node_reg : chosen;
        start_ext   = XW'((start_node << k_reg) - NW'(LEAVES));
        page_ext    = XW'(req.page_index);
        if (free_reg && (val_reg == full_mask(h_reg)) && (rd_b_reg == full_mask(h_reg)))
        begin
            merged = full_mask(h_inc);
        end
        else
        begin
            merged = val_reg | rd_b_reg;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        node_next        = node_reg;
        h_next           = h_reg;
        k_next           = k_reg;
        val_next         = val_reg;
        free_next        = free_reg;
        used_next        = used_reg;
        pend_status_next = pend_status_reg;
        pend_start_next  = pend_start_reg;
        rd_en            = 1'b0;
        rd_a_addr        = '0;
        rd_b_addr        = '0;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = '0;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_start_next   = out_start_reg;
        out_used_next    = out_used_reg;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en     = 1'b1;
                wr_addr   = node_reg;
                wr_data   = full_mask(h_reg);
                node_next = node_inc;
                if (node_reg == NW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else if ((node_inc & (node_inc - NW'(1))) == '0)
                begin
                    // first node of the next level down
                    h_next = h_dec;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    free_next = (req.cmd == bpa_pkg::CMD_FREE);
                    k_next    = order;
                    if (req.cmd == bpa_pkg::CMD_ALLOC)
                    begin
                        if (size_bad)
                        begin
                            pend_status_next = bpa_pkg::ST_BAD_SIZE;
                            pend_start_next  = '0;
                            state_next       = S_DONE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_a_addr  = NW'(1);
                            node_next  = NW'(1);
                            h_next     = KW'(LVL);
                            state_next = S_AROOT;
                        end
                    end
                    else if (page_ext >= XW'(LEAVES))
                    begin
                        pend_status_next = bpa_pkg::ST_NOT_ALLOC;
                        pend_start_next  = '0;
                        state_next       = S_DONE;
                    end
                    else
                    begin
                        pend_start_next = req.page_index;
                        node_next       = NW'(LEAVES) + NW'(req.page_index);
                        h_next          = '0;
                        rd_en           = 1'b1;
                        rd_a_addr       = NW'(LEAVES) + NW'(req.page_index);
                        rd_b_addr       = (NW'(LEAVES) + NW'(req.page_index)) ^ NW'(1);
                        state_next      = S_FSRCH;
                    end
                end
            end

            S_AROOT:
            begin
                if ((rd_a_reg & bit_k) == '0)
                begin
                    pend_status_next = bpa_pkg::ST_NO_FREE;
                    pend_start_next  = '0;
                    state_next       = S_DONE;
                end
                else if (h_reg == k_reg)
                begin
                    // whole tree taken in one block
                    wr_en            = 1'b1;
                    wr_addr          = node_reg;
                    wr_data          = '0;
                    used_next        = used_reg + CW'(bit_k);
                    pend_status_next = bpa_pkg::ST_OK;
                    pend_start_next  = start_ext[bpa_pkg::PAGE_W-1:0];
                    state_next       = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_a_addr  = {node_reg[NW-2:0], 1'b0};
                    rd_b_addr  = {node_reg[NW-2:0], 1'b1};
                    state_next = S_ADOWN;
                end
            end

            S_ADOWN:
            begin
                if ((chosen_mask & bit_k) == '0)
                begin
                    pend_status_next = bpa_pkg::ST_NO_FREE;
                    pend_start_next  = '0;
                    state_next       = S_DONE;
                end
                else
                begin
                    node_next = chosen;
                    h_next    = h_dec;
                    rd_en     = 1'b1;
                    if (h_dec == k_reg)
                    begin
                        wr_en            = 1'b1;
                        wr_addr          = chosen;
                        wr_data          = '0;
                        used_next        = used_reg + CW'(bit_k);
                        pend_status_next = bpa_pkg::ST_OK;
                        pend_start_next  = start_ext[bpa_pkg::PAGE_W-1:0];
                        val_next         = '0;
                        rd_b_addr        = chosen ^ NW'(1);
                        state_next       = S_UP;
                    end
                    else
                    begin
                        rd_a_addr = {chosen[NW-2:0], 1'b0};
                        rd_b_addr = {chosen[NW-2:0], 1'b1};
                    end
                end
            end

            S_FSRCH:
            begin
                if (rd_a_reg == '0)
                begin
                    // sibling stays in rd_b_reg for the first merge step
                    wr_en            = 1'b1;
                    wr_addr          = node_reg;
                    wr_data          = full_mask(h_reg);
                    used_next        = used_reg - (CW'(1) << h_reg);
                    pend_status_next = bpa_pkg::ST_OK;
                    val_next         = full_mask(h_reg);
                    state_next       = (node_reg == NW'(1)) ? S_DONE : S_UP;
                end
                else if ((node_reg == NW'(1)) || node_reg[0])
                begin
                    pend_status_next = bpa_pkg::ST_NOT_ALLOC;
                    pend_start_next  = '0;
                    state_next       = S_DONE;
                end
                else
                begin
                    node_next = parent;
                    h_next    = h_inc;
                    rd_en     = 1'b1;
                    rd_a_addr = parent;
                    rd_b_addr = parent ^ NW'(1);
                end
            end

            S_UP:
            begin
                wr_en   = 1'b1;
                wr_addr = parent;
                wr_data = merged;
                if (parent == NW'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    node_next = parent;
                    h_next    = h_inc;
                    val_next  = merged;
                    rd_en     = 1'b1;
                    rd_a_addr = parent;
                    rd_b_addr = parent ^ NW'(1);
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_start_next  = pend_start_reg;
                    out_used_next   = used_reg[bpa_pkg::USED_W-1:0];
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            node_reg      <= NW'(1);
            h_reg         <= KW'(LVL);
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            node_reg      <= node_next;
            h_reg         <= h_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg           <= k_next;
        val_reg         <= val_next;
        free_reg        <= free_next;
        pend_status_reg <= pend_status_next;
        pend_start_reg  <= pend_start_next;
        out_status_reg  <= out_status_next;
        out_start_reg   <= out_start_next;
        out_used_reg    <= out_used_next;
    end

endmodule
